// File: design/rrt_pkg.sv
// shared types, sizes and request codes of the relay route table
package rrt_pkg;

    // table size and derived index widths
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int HASH_W  = 64;

    // request codes
    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_INVAL  = 2'd2
    } t_req_code;

    // input word
    typedef struct packed {
        logic [1:0]        req_type;
        logic [HASH_W-1:0] dest_hash;
        logic [HASH_W-1:0] next_hash;
        logic [HASH_W-1:0] origin_hash;
    } t_req;

    // result word
    typedef struct packed {
        logic [HASH_W-1:0] found_next_hash;
        logic              hit;
        logic              status;
    } t_rsp;

    // one stored slot
    typedef struct packed {
        logic [HASH_W-1:0] key;
        logic [HASH_W-1:0] next;
        logic [HASH_W-1:0] origin;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage

// File: design/rrt_ram.sv
// generic single-port-write ram with registered read
module rrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/relay_route_table.sv
// relay route table: slot scan sequencer around one shared 64-bit compare
//
// Usage:
//   A request word is taken on i_req at a rising edge where start is high and
//   busy is low. busy stays high until the request is finished. One result
//   word per request appears on o_rsp for exactly one cycle with o_done high.
//   The receiver cannot stall; o_done is a single-cycle strobe.
// Operation:
//   Slots fill from index 0 upward and are never freed, so a fill count marks
//   the used slots. Key, next hop and origin live in one ram; the used slots
//   are read one per cycle and compared by a single comparator.
// Scan:
//   a request reads at most one ram word per used slot, waits for the
//   registered read, then passes the finish state and the output register
//   before o_done; lookup and update stop early on the first match. busy is
//   low again when o_done is shown, so a new request may start in that cycle.
// Reset:
//   synchronous active-low reset clears the fill count and the valid marks;
//   no clearing pass over the ram is needed and the block is ready at once.
module relay_route_table
    import rrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_pidx, n_pidx;
    logic              r_pend, n_pend;
    logic              r_hit, n_hit;
    logic [IDX_W-1:0]  r_midx, n_midx;
    logic [HASH_W-1:0] r_mnext, n_mnext;
    logic [HASH_W-1:0] r_morigin, n_morigin;
    logic              r_valid [ENTRIES];
    logic              r_done, n_done;
    t_rsp              r_rsp, n_rsp;

    logic              w_accept;
    logic              w_is_inv;
    logic              w_is_look;
    logic              w_issue;
    logic              w_cmp_eq;
    logic              w_match;
    logic              w_last;
    logic              w_full;
    logic [HASH_W-1:0] w_cmp_a;
    logic [HASH_W-1:0] w_cmp_b;
    logic [SLOT_W-1:0] w_rdata;
    t_slot             w_rd;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    t_slot             w_wslot;
    logic              w_set_valid;

    // slot storage
    rrt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (SLOT_W'(w_wslot)),
        .i_re    (w_issue),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rd      = t_slot'(w_rdata);
    assign w_accept  = start && !busy;
    assign w_is_inv  = (r_req.req_type == REQ_INVAL);
    assign w_is_look = (r_req.req_type == REQ_LOOKUP);
    assign w_full    = (r_fill == CNT_W'(ENTRIES));

    // shared comparator: key for lookup and update, origin for invalidate
    assign w_cmp_a  = w_is_inv ? w_rd.origin : w_rd.key;
    assign w_cmp_b  = w_is_inv ? r_req.origin_hash : r_req.dest_hash;
    assign w_cmp_eq = (w_cmp_a == w_cmp_b);

    // scan control
    assign w_issue = (r_state == S_SCAN) && (r_idx != r_fill);
    assign w_match = r_pend && w_cmp_eq && (!w_is_look || r_valid[r_pidx]);
    assign w_last  = r_pend && (r_idx == r_fill);

    // finish-cycle write: overwrite the matched slot or claim the next free one
    always_comb begin
        w_we        = 1'b0;
        w_set_valid = 1'b0;
        w_waddr     = r_midx;
        w_wslot     = '{key: r_req.dest_hash, next: r_req.next_hash,
                        origin: r_morigin};
        if (r_state == S_DONE && r_req.req_type == REQ_UPDATE) begin
            if (r_hit) begin
                w_we        = 1'b1;
                w_set_valid = 1'b1;
            end else if (!w_full) begin
                w_we           = 1'b1;
                w_set_valid    = 1'b1;
                w_waddr        = r_fill[IDX_W-1:0];
                w_wslot.origin = r_req.origin_hash;
            end
        end
    end

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_pend    = 1'b0;
        n_hit     = r_hit;
        n_midx    = r_midx;
        n_mnext   = r_mnext;
        n_morigin = r_morigin;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req = i_req;
                    n_idx = '0;
                    n_hit = 1'b0;
                    if (i_req.req_type != 2'(REQ_LOOKUP) &&
                        i_req.req_type != 2'(REQ_UPDATE) &&
                        i_req.req_type != 2'(REQ_INVAL)) begin
                        n_state = S_DONE;
                    end else if (r_fill == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_pend = w_issue;
                if (w_issue) begin
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + CNT_W'(1);
                end
                if (w_match && !w_is_inv) begin
                    n_hit     = 1'b1;
                    n_midx    = r_pidx;
                    n_mnext   = w_rd.next;
                    n_morigin = w_rd.origin;
                    n_pend    = 1'b0;
                    n_state   = S_DONE;
                end else if (w_last) begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_done                = 1'b1;
                n_rsp.hit             = w_is_look && r_hit;
                n_rsp.found_next_hash = (w_is_look && r_hit) ? r_mnext : '0;
                n_rsp.status          = (r_req.req_type == REQ_UPDATE) && !r_hit && w_full;
                if (w_we && !r_hit) begin
                    n_fill = r_fill + CNT_W'(1);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_hit     <= n_hit;
        r_midx    <= n_midx;
        r_mnext   <= n_mnext;
        r_morigin <= n_morigin;
        r_rsp     <= n_rsp;
    end

    // valid marks: cleared by invalidate matches, set by update writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (r_state == S_SCAN && w_is_inv && w_match) begin
                r_valid[r_pidx] <= 1'b0;
            end
            if (w_set_valid) begin
                r_valid[w_waddr] <= 1'b1;
            end
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // checks
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(ENTRIES))
        else $error("fill count beyond table size");

    a_done_follows_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_DONE))
        else $error("result strobe without a finish cycle");

    a_busy_drop_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    a_hit_only_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.hit) |-> (r_req.req_type == REQ_LOOKUP))
        else $error("hit reported on a non-lookup request");

    a_write_in_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_DONE && !w_issue))
        else $error("slot write outside finish cycle");

endmodule

// File: tb/relay_route_table_test.sv
// self-checking testbench for the relay route table with a scoreboard class
module relay_route_table_test
    import rrt_pkg::*;
();

    // spare request code the block must answer with an all-zero word
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int RANDOM_WORDS  = 450;
    localparam int KEY_POOL      = 20;
    localparam int ORIGIN_POOL   = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 25;

    // table mirror and queue of expected result words
    class route_table_scoreboard;
        bit                slot_used   [ENTRIES];
        bit                slot_valid  [ENTRIES];
        logic [HASH_W-1:0] slot_key    [ENTRIES];
        logic [HASH_W-1:0] slot_next   [ENTRIES];
        logic [HASH_W-1:0] slot_origin [ENTRIES];
        t_rsp              pending[$];
        int errors, hits, misses, refreshes, inserts, drops, invals, cleared, spares;

        function new();
            foreach (slot_used[i]) begin
                slot_used[i]  = 1'b0;
                slot_valid[i] = 1'b0;
            end
            errors = 0;
        endfunction

        // apply one accepted request word to the mirror and queue its result
        function void note_request(t_req w);
            t_rsp r;
            int   match;
            int   free_idx;
            r        = '0;
            match    = -1;
            free_idx = -1;
            case (w.req_type)
                REQ_LOOKUP: begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (match < 0 && slot_used[i] && slot_valid[i]
                                && slot_key[i] == w.dest_hash)
                            match = i;
                    if (match >= 0) begin
                        r.found_next_hash = slot_next[match];
                        r.hit = 1'b1;
                        hits++;
                    end else begin
                        misses++;
                    end
                end
                REQ_UPDATE: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot_used[i]) begin
                            if (match < 0 && slot_key[i] == w.dest_hash)
                                match = i;
                        end else if (free_idx < 0) begin
                            free_idx = i;
                        end
                    end
                    if (match >= 0) begin
                        slot_next[match]  = w.next_hash;
                        slot_valid[match] = 1'b1;
                        refreshes++;
                    end else if (free_idx >= 0) begin
                        slot_used[free_idx]   = 1'b1;
                        slot_valid[free_idx]  = 1'b1;
                        slot_key[free_idx]    = w.dest_hash;
                        slot_next[free_idx]   = w.next_hash;
                        slot_origin[free_idx] = w.origin_hash;
                        inserts++;
                    end else begin
                        r.status = 1'b1;
                        drops++;
                    end
                end
                REQ_INVAL: begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot_used[i] && slot_origin[i] == w.origin_hash) begin
                            if (slot_valid[i])
                                cleared++;
                            slot_valid[i] = 1'b0;
                        end
                    invals++;
                end
                default: begin
                    spares++;
                end
            endcase
            pending.push_back(r);
        endfunction

        // compare a result word with the oldest expectation
        function void check_result(t_rsp got);
            t_rsp want;
            if (pending.size() == 0) begin
                $display("%0t: result word with nothing pending: found %h hit %b status %b",
                         $time, got.found_next_hash, got.hit, got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.found_next_hash !== want.found_next_hash) begin
                $display("%0t: found_next_hash expected %h actual %h",
                         $time, want.found_next_hash, got.found_next_hash);
                errors++;
            end
            if (got.hit !== want.hit) begin
                $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %b actual %b", $time, want.status, got.status);
                errors++;
            end
        endfunction

        function int filled();
            int n;
            n = 0;
            foreach (slot_used[i])
                n += slot_used[i];
            return n;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_done;
    t_rsp o_rsp;

    route_table_scoreboard sb;
    logic [HASH_W-1:0]     key_pool    [KEY_POOL];
    logic [HASH_W-1:0]     origin_pool [ORIGIN_POOL];
    int                    stall_cycles;

    relay_route_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // observe accepted request words and result words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                sb.check_result(o_rsp);
            if (start && !busy)
                sb.note_request(i_req);
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL relay_route_table");
            $finish;
        end
    end

    function automatic logic [HASH_W-1:0] rand_hash();
        return {$urandom, $urandom};
    endfunction

    function automatic t_req make_word(logic [1:0] code, logic [HASH_W-1:0] dest,
                                       logic [HASH_W-1:0] nxt, logic [HASH_W-1:0] origin);
        t_req w;
        w.req_type    = code;
        w.dest_hash   = dest;
        w.next_hash   = nxt;
        w.origin_hash = origin;
        return w;
    endfunction

    // mostly pooled keys and origins so lookups hit and invalidates match
    function automatic t_req random_word();
        t_req w;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            w.req_type = REQ_LOOKUP;
        else if (pick < 72)
            w.req_type = REQ_UPDATE;
        else if (pick < 94)
            w.req_type = REQ_INVAL;
        else
            w.req_type = REQ_SPARE;
        w.dest_hash   = ($urandom_range(0, 99) < 85) ?
                        key_pool[$urandom_range(0, KEY_POOL - 1)] : rand_hash();
        w.next_hash   = ($urandom_range(0, 99) < 5) ? '0 : rand_hash();
        w.origin_hash = ($urandom_range(0, 99) < 90) ?
                        origin_pool[$urandom_range(0, ORIGIN_POOL - 1)] : rand_hash();
        return w;
    endfunction

    // present one word, optionally after a random gap; returns at a falling edge
    task automatic send_word(t_req w, bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 99) < 16) begin
            gap = $urandom_range(1, 24);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= w;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold off until every expected result word has come back
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge i_clk);
        while (sb.pending.size() != 0);
    endtask

    initial begin
        sb      = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        foreach (key_pool[k])
            key_pool[k] = rand_hash();
        key_pool[0] = '0;
        key_pool[1] = '1;
        foreach (origin_pool[k])
            origin_pool[k] = rand_hash();
        origin_pool[0] = '1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, spare code, extremes, refresh and invalidate
        send_word(make_word(REQ_LOOKUP, '0, '0, '0), 1'b0);
        send_word(make_word(REQ_INVAL, '0, '0, '1), 1'b0);
        send_word(make_word(REQ_SPARE, '1, '1, '1), 1'b0);
        send_word(make_word(REQ_UPDATE, '0, '1, origin_pool[1]), 1'b0);
        send_word(make_word(REQ_UPDATE, '1, '0, '1), 1'b0);
        send_word(make_word(REQ_LOOKUP, '1, '1, '1), 1'b0);
        send_word(make_word(REQ_LOOKUP, '0, '0, '0), 1'b0);
        send_word(make_word(REQ_UPDATE, '0, 64'h0123_4567_89ab_cdef, '0), 1'b0);
        send_word(make_word(REQ_LOOKUP, '0, '0, '0), 1'b0);
        // refresh with another origin keeps the stored one
        send_word(make_word(REQ_INVAL, '0, '0, '0), 1'b0);
        send_word(make_word(REQ_LOOKUP, '0, '1, '1), 1'b0);
        send_word(make_word(REQ_INVAL, '1, '1, origin_pool[1]), 1'b0);
        send_word(make_word(REQ_LOOKUP, '0, '0, '0), 1'b0);
        send_word(make_word(REQ_LOOKUP, '1, '0, '0), 1'b0);
        // update of an invalid slot revalidates it
        send_word(make_word(REQ_UPDATE, '0, 64'hfedc_ba98_7654_3210, '1), 1'b0);
        send_word(make_word(REQ_LOOKUP, '0, '0, '0), 1'b0);
        send_word(make_word(REQ_INVAL, '0, '0, '1), 1'b0);
        send_word(make_word(REQ_LOOKUP, '1, '0, '0), 1'b0);
        send_word(make_word(REQ_LOOKUP, 64'h5555_aaaa_5555_aaaa, '0, '0), 1'b0);
        send_word(make_word(REQ_SPARE, '0, '0, '0), 1'b0);
        drain();

        // random words, with a stretch of back-to-back requests and one drain
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 300)
                drain();
            send_word(random_word(), !(n >= 150 && n < 250));
        end
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d lookup hits, %0d misses, %0d refreshes, %0d inserts, %0d drops",
                 sb.hits, sb.misses, sb.refreshes, sb.inserts, sb.drops);
        $display("covered %0d invalidates clearing %0d slots, %0d spare codes",
                 sb.invals, sb.cleared, sb.spares);
        $display("%0d of %0d slots used at the end", sb.filled(), ENTRIES);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS relay_route_table");
        else
            $display("FAIL relay_route_table");
        $finish;
    end

endmodule
